// ===== rtl/luma_block_predictive_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the luma block predictive encoder
// Shared wrappers so that every check is written in the same clocked form.
// ----------------------------------------------------------------------------
`ifndef LUMA_BLOCK_PREDICTIVE_ENCODER_ASSERT_SVH
`define LUMA_BLOCK_PREDICTIVE_ENCODER_ASSERT_SVH

// Plain property, sampled on the rising clock edge, idle while in reset.
`define LBPE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication from a trigger to a consequence.
`define LBPE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpe_pkg
// Types, field widths and the fixed variable-length code table of the encoder.
// ----------------------------------------------------------------------------
package lbpe_pkg;

  localparam int unsigned LUMA_W   = 6;
  localparam int unsigned CHROMA_W = 5;
  localparam int unsigned BITS_W   = 12;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned IN_W     = LUMA_W + 2 * CHROMA_W;
  localparam int unsigned OUT_W    = BITS_W + LEN_W;
  localparam int unsigned SUM_W    = 10;

  // Input tuser bit positions.
  localparam int unsigned TUSER_SMALL = 0;
  localparam int unsigned TUSER_FRAME = 1;

  // Header opcodes and length.
  localparam logic [1:0]       OP_BLOCK_4X4 = 2'd1;
  localparam logic [1:0]       OP_BLOCK_2X2 = 2'd2;
  localparam logic [LEN_W-1:0] HEADER_LEN   = 4'd12;

  // One result as held in the output queue.
  typedef struct packed {
    logic             is_header;
    logic             last;
    logic [OUT_W-1:0] data;   // code length in the top four bits, code value below
  } lbpe_res_t;

  // Each entry is {code length, code value}, matching the output tdata layout.
  localparam logic [OUT_W-1:0] VLC_TABLE [64] = '{
    16'h2002, 16'h3007, 16'h400d, 16'h5019, 16'h501c, 16'h5018, 16'h6031, 16'h6034,
    16'h6030, 16'h7061, 16'h706c, 16'h7050, 16'h80c1, 16'h80cc, 16'h80e8, 16'h91a1,
    16'h918c, 16'h91d4, 16'h9194, 16'h9190, 16'ha2a1, 16'ha341, 16'ha34c, 16'ha294,
    16'ha314, 16'hb541, 16'hb141, 16'hb68c, 16'hb54c, 16'hb14c, 16'hb494, 16'hb614,
    16'hb690, 16'hb290, 16'hb710, 16'hb310, 16'hb414, 16'hb014, 16'hb214, 16'hb094,
    16'hb28c, 16'ha090, 16'ha110, 16'ha114, 16'ha08c, 16'ha0a1, 16'h9010, 16'h90d4,
    16'h904c, 16'h9041, 16'h8068, 16'h8054, 16'h800c, 16'h8021, 16'h7028, 16'h702c,
    16'h7001, 16'h6008, 16'h6011, 16'h5000, 16'h5004, 16'h5009, 16'h4005, 16'h3003
  };

endpackage

// ===== rtl/luma_block_predictive_encoder.sv =====
// ----------------------------------------------------------------------------
// Luma block predictive encoder
// Predicts each 6-bit luma sample of a 4x4 or 2x2 block from its neighbours
// and emits a block header plus one variable-length codeword per sample.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit first)              tuser / tlast
//  --------  ---------  ---------------------------------  -------------------------------
//  s_axis    in         luma[5:0] chroma_u[4:0] chroma_v   tuser: block_is_2x2, frame_start
//  m_axis    out        code_bits[11:0] code_length[3:0]   tuser: is_header; tlast: last
//  cfg       in         predictor_start[5:0]               (write enable only)
//
// Each accepted request is fully encoded in the cycle it is accepted and its
// results are written into a four-entry output queue, so a new request can be
// taken every cycle while the queue has room. The first sample of a block yields
// two results (header and codeword), every other sample one, so the sustained
// rate is set by the single output port, which also carries each header.
// The input is ready whenever the queue has room for two results, so a stalled
// output holds the input back after at most two further requests.
// Reset (rst_ni low, asynchronous) clears the block position, neighbour
// samples, running sum, predictor, configuration and the queue.

module luma_block_predictive_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lbpe_pkg::LUMA_W-1:0]   cfg_wdata_i,   // predictor_start
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lbpe_pkg::IN_W-1:0]     s_axis_tdata,  // luma, chroma_u, chroma_v
  input  logic [1:0]                    s_axis_tuser,  // block_is_2x2, frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lbpe_pkg::OUT_W-1:0]    m_axis_tdata,  // code_bits, code_length
  output logic                          m_axis_tuser,  // is_header
  output logic                          m_axis_tlast   // last_of_block
);
  import lbpe_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = PTR_W + 1;

  // Block state.
  logic [3:0]        pos_q, pos_d;
  logic [LUMA_W-1:0] above_q [4];
  logic [LUMA_W-1:0] left_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [LUMA_W-1:0] cross_q, cross_d;
  logic              small_q, small_d;
  logic [LUMA_W-1:0] pstart_q;

  // Output queue.
  lbpe_res_t         queue_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q, count_d;

  // Request fields.
  logic [LUMA_W-1:0]   luma;
  logic [CHROMA_W-1:0] chroma_u, chroma_v;

  logic              in_fire, out_fire, first;
  logic [LUMA_W-1:0] cross_cur, pred, resid;
  logic [SUM_W-1:0]  sum_base;
  logic [1:0]        row, col;
  logic [LUMA_W:0]   pair_sum;
  logic [4:0]        pos_inc, pix_count;
  logic              last;
  lbpe_res_t         header_res, code_res;

  assign luma     = s_axis_tdata[LUMA_W-1:0];
  assign chroma_u = s_axis_tdata[LUMA_W+CHROMA_W-1:LUMA_W];
  assign chroma_v = s_axis_tdata[IN_W-1:LUMA_W+CHROMA_W];

  assign s_axis_tready = (count_q <= CNT_W'(QDEPTH - 2));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count_q != '0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign first = (pos_q == 4'd0);

  always_comb begin
    // Block size and frame reload are taken from the request on the first sample only.
    small_d   = first ? s_axis_tuser[TUSER_SMALL] : small_q;
    cross_cur = (first && s_axis_tuser[TUSER_FRAME]) ? pstart_q : cross_q;
    sum_base  = first ? '0 : sum_q;

    if (small_d) begin
      row = {1'b0, pos_q[1]};
      col = {1'b0, pos_q[0]};
    end else begin
      row = pos_q[3:2];
      col = pos_q[1:0];
    end

    pair_sum = {1'b0, left_q} + {1'b0, above_q[col]};
    priority if (row == 2'd0) begin
      pred = (col == 2'd0) ? cross_cur : left_q;
    end else if (col == 2'd0) begin
      pred = above_q[0];
    end else begin
      pred = pair_sum[LUMA_W:1];
    end
    resid = luma - pred;

    pos_inc   = {1'b0, pos_q} + 5'd1;
    pix_count = small_d ? 5'd4 : 5'd16;
    last      = (pos_inc >= pix_count);
    sum_d     = sum_base + SUM_W'(luma);

    // At the end of a block the predictor becomes the mean luma of the block.
    if (last) begin
      cross_d = small_d ? sum_d[LUMA_W+1:2] : sum_d[LUMA_W+3:4];
      pos_d   = 4'd0;
    end else begin
      cross_d = cross_cur;
      pos_d   = pos_inc[3:0];
    end

    header_res.is_header = 1'b1;
    header_res.last      = 1'b0;
    header_res.data      = {HEADER_LEN, chroma_v, chroma_u,
                            (small_d ? OP_BLOCK_2X2 : OP_BLOCK_4X4)};
    code_res.is_header   = 1'b0;
    code_res.last        = last;
    code_res.data        = VLC_TABLE[resid];

    count_d = count_q + (in_fire ? (first ? CNT_W'(2) : CNT_W'(1)) : '0)
                      - (out_fire ? CNT_W'(1) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      for (int i = 0; i < 4; i++) above_q[i] <= '0;
      left_q   <= '0;
      sum_q    <= '0;
      cross_q  <= '0;
      small_q  <= 1'b0;
      pstart_q <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        pstart_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        pos_q        <= pos_d;
        above_q[col] <= luma;
        left_q       <= luma;
        sum_q        <= last ? '0 : sum_d;
        cross_q      <= cross_d;
        small_q      <= small_d;
        wr_ptr_q     <= wr_ptr_q + (first ? PTR_W'(2) : PTR_W'(1));
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (first) begin
        queue_q[wr_ptr_q]             <= header_res;
        queue_q[wr_ptr_q + PTR_W'(1)] <= code_res;
      end else begin
        queue_q[wr_ptr_q] <= code_res;
      end
    end
  end

  assign m_axis_tdata = queue_q[rd_ptr_q].data;
  assign m_axis_tuser = queue_q[rd_ptr_q].is_header;
  assign m_axis_tlast = queue_q[rd_ptr_q].last;

endmodule

// ===== rtl/lbpe_checker.sv =====
// ----------------------------------------------------------------------------
// lbpe_checker
// Port-level checks of the luma block predictive encoder, bound to the top.
// ----------------------------------------------------------------------------
`include "luma_block_predictive_encoder_assert.svh"

module lbpe_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [lbpe_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                       m_axis_tuser,
  input logic                       m_axis_tlast
);
  import lbpe_pkg::*;

  // A header never closes a block.
  `LBPE_ASSERT_IMPL(a_header_not_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, !m_axis_tlast, "header marked as last of block")

  // A header always carries the full twelve-bit length.
  `LBPE_ASSERT_IMPL(a_header_len, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[OUT_W-1:BITS_W] == HEADER_LEN, "header length is not twelve")

  // After every accepted request the output holds a valid result on the next cycle.
  `LBPE_ASSERT(a_result_follows, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid, "no result after an accepted request")

  // A stalled result holds its payload.
  `LBPE_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled result changed")

endmodule

bind luma_block_predictive_encoder lbpe_checker u_lbpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
